// ----- design/sensor_slot_map_and_qualifier_unit_assert.svh -----
// ----------------------------------------------------------------------------
// sensor slot map assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef SENSOR_SLOT_MAP_AND_QUALIFIER_UNIT_ASSERT_SVH
`define SENSOR_SLOT_MAP_AND_QUALIFIER_UNIT_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define SSMQ_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("ssmq assertion failed");

// condition holds in the cycle after its trigger
`define SSMQ_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("ssmq assertion failed");

`endif

// ----- design/ssmq_pkg.sv -----
// ----------------------------------------------------------------------------
// ssmq_pkg
// types and constants of the sensor slot map and qualifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssmq_pkg;

  localparam int KEY_W              = 32;
  localparam int ADDR_W             = 64;
  localparam int TEMP_W             = 16;
  localparam int CNT_W              = 10;
  localparam int OUT_IDX_W          = 3;
  localparam int SLOT_COUNT_DEFAULT = 8;

  localparam logic [CNT_W-1:0] COUNT_LIMIT   = CNT_W'(1000);
  localparam logic [CNT_W-1:0] QUALIFY_RESET = CNT_W'(3);

  // input item kinds
  typedef enum logic {
    OP_READING   = 1'b0,
    OP_END_ROUND = 1'b1
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_CMP,
    S_APPEND,
    S_END_RD,
    S_END_OUT
  } state_t;

endpackage

// ----- design/ssmq_ram.sv -----
// ----------------------------------------------------------------------------
// ssmq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sensor_slot_map_and_qualifier_unit.sv -----
// A reading beat visits filled slots in the key scan one at a time, each in a
// key read and a key compare state, and returns to idle when the key is found
// or goes to the append state when not; an end-of-round beat walks every slot
// through a read and an output state, the output state waiting while the
// output side stalls. One sequencer walks the slot memories through their
// single registered read port, one slot at a time. in_ready is high only
// while the sequencer is idle; the last result of a round may still wait in
// the output register while the next beat is taken. Readings return no result;
// an end-of-round beat returns SLOT_COUNT results, the final one marked last.
// ----------------------------------------------------------------------------
// sensor_slot_map_and_qualifier_unit
// maps reporting sensors onto slots by address key and qualifies each
// slot's temperature over consecutive conversion rounds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_slot_map_and_qualifier_unit #(
  parameter int SLOT_COUNT = ssmq_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [ssmq_pkg::CNT_W-1:0]            cfg_wdata,
  // input beats
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic [ssmq_pkg::ADDR_W-1:0]           sensor_address,
  input  logic signed [ssmq_pkg::TEMP_W-1:0]    temperature,
  // result beats
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ssmq_pkg::OUT_IDX_W-1:0]        slot_index,
  output logic signed [ssmq_pkg::TEMP_W-1:0]    slot_temperature,
  output logic                                  has_value,
  output logic                                  awaiting,
  output logic                                  any_sensor_seen,
  output logic                                  last
);

  import ssmq_pkg::*;

  `include "sensor_slot_map_and_qualifier_unit_assert.svh"

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int USED_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [USED_W-1:0] FULL_USED = USED_W'(SLOT_COUNT);

  state_t state, state_next;

  logic [CNT_W-1:0]       qualify_rounds;
  logic [USED_W-1:0]      slots_used;
  logic [IDX_W-1:0]       idx;
  logic [KEY_W-1:0]       key;
  logic [TEMP_W-1:0]      temp;
  logic                   seen_flag;
  logic [SLOT_COUNT-1:0]  round_has_value;
  logic [SLOT_COUNT-1:0]  count_valid;

  logic                   in_fire;
  logic                   out_free;
  logic                   out_load;
  logic                   key_match;
  logic [USED_W-1:0]      idx_inc;
  logic [IDX_W-1:0]       append_idx;

  logic                   key_we;
  logic                   val_we;
  logic [IDX_W-1:0]       val_waddr;
  logic                   cnt_we;
  logic [KEY_W-1:0]       key_rdata;
  logic [TEMP_W-1:0]      val_rdata;
  logic [CNT_W-1:0]       cnt_rdata;

  logic                   slot_hv;
  logic [CNT_W-1:0]       cnt_old;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W-1:0]       cnt_new;
  logic                   show;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign key_match  = (key_rdata == key);
  assign idx_inc    = USED_W'(idx) + USED_W'(1);
  assign append_idx = IDX_W'(slots_used);

  // count update for the slot under the round-end walk
  assign slot_hv = round_has_value[idx];
  assign cnt_old = count_valid[idx] ? cnt_rdata : '0;
  assign cnt_inc = (cnt_old < COUNT_LIMIT) ? cnt_old + CNT_W'(1) : cnt_old;
  assign cnt_new = slot_hv ? cnt_inc : '0;
  assign show    = slot_hv && (cnt_new >= qualify_rounds);

  // slot key, round value and round count memories
  ssmq_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (append_idx),
    .wdata (key),
    .raddr (idx),
    .rdata (key_rdata)
  );

  ssmq_ram #(.WIDTH(TEMP_W), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (temp),
    .raddr (idx),
    .rdata (val_rdata)
  );

  ssmq_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx),
    .wdata (cnt_new),
    .raddr (idx),
    .rdata (cnt_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and memory strobes
  always_comb begin
    state_next = state;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = idx;
    cnt_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode == OP_END_ROUND) begin
            state_next = S_END_RD;
          end else if (slots_used == '0) begin
            state_next = S_APPEND;
          end else begin
            state_next = S_KEY_RD;
          end
        end
      end
      S_KEY_RD: begin
        state_next = S_KEY_CMP;
      end
      S_KEY_CMP: begin
        if (key_match) begin
          val_we     = 1'b1;
          state_next = S_IDLE;
        end else if (idx_inc < slots_used) begin
          state_next = S_KEY_RD;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        if (slots_used < FULL_USED) begin
          key_we    = 1'b1;
          val_we    = 1'b1;
          val_waddr = append_idx;
        end
        state_next = S_IDLE;
      end
      S_END_RD: begin
        state_next = S_END_OUT;
      end
      S_END_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          cnt_we     = 1'b1;
          state_next = (idx == LAST_IDX) ? S_IDLE : S_END_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers: config, fill count, flags, slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      qualify_rounds  <= QUALIFY_RESET;
      slots_used      <= '0;
      seen_flag       <= 1'b0;
      round_has_value <= '0;
      count_valid     <= '0;
      idx             <= '0;
    end else begin
      if (cfg_we) begin
        qualify_rounds <= cfg_wdata;
      end
      if (in_fire) begin
        idx <= '0;
        if (opcode == OP_READING) begin
          seen_flag <= 1'b1;
        end
      end
      if (state == S_KEY_CMP && !key_match && idx_inc < slots_used) begin
        idx <= idx + IDX_W'(1);
      end
      if (state == S_KEY_CMP && key_match) begin
        round_has_value[idx] <= 1'b1;
      end
      if (key_we) begin
        round_has_value[append_idx] <= 1'b1;
        slots_used                  <= slots_used + USED_W'(1);
      end
      if (out_load) begin
        round_has_value[idx] <= 1'b0;
        count_valid[idx]     <= 1'b1;
        if (idx != LAST_IDX) begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // captured reading payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key  <= (sensor_address[KEY_W-1:0] ^ sensor_address[ADDR_W-1:KEY_W]) | KEY_W'(1);
      temp <= temperature;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_index       <= OUT_IDX_W'(idx);
      slot_temperature <= show ? val_rdata : '0;
      has_value        <= show;
      awaiting         <= slot_hv && !show;
      any_sensor_seen  <= seen_flag;
      last             <= (idx == LAST_IDX);
    end
  end

  // checks
  `SSMQ_ASSERT_SAME(a_used_in_range, 1'b1, slots_used <= FULL_USED)
  `SSMQ_ASSERT_SAME(a_round_walk_open, out_valid && !last,
    state == S_END_RD || state == S_END_OUT)
  `SSMQ_ASSERT_SAME(a_shown_or_waiting, out_valid, !(has_value && awaiting))
  `SSMQ_ASSERT_SAME(a_hidden_zero, out_valid && !has_value, slot_temperature == '0)
  `SSMQ_ASSERT_NEXT(a_append_grows, key_we, slots_used == $past(slots_used) + USED_W'(1))

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the sensor slot map and qualifier: readings and
// end-of-round beats go in, a local model of slot assignment and round
// qualification predicts every slot result, and a monitor checks each field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ssmq_pkg::*;

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PRINT_CAP    = 100;
  localparam logic [ADDR_W-1:0] STRAY_ADDR = 64'hA5A5A5A5_0F0F0F0F;

  typedef struct {
    opcode_t                  op;
    logic [ADDR_W-1:0]        addr;
    logic signed [TEMP_W-1:0] temp;
  } sensor_beat_t;

  typedef struct {
    logic [OUT_IDX_W-1:0]     idx;
    logic signed [TEMP_W-1:0] temp;
    logic                     shown;
    logic                     waiting;
    logic                     seen;
    logic                     final_slot;
  } slot_report_t;

  // dut ports
  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     cfg_we         = 1'b0;
  logic [CNT_W-1:0]         cfg_wdata      = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic                     opcode         = 1'b0;
  logic [ADDR_W-1:0]        sensor_address = '0;
  logic signed [TEMP_W-1:0] temperature    = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic [OUT_IDX_W-1:0]     slot_index;
  logic signed [TEMP_W-1:0] slot_temperature;
  logic                     has_value;
  logic                     awaiting;
  logic                     any_sensor_seen;
  logic                     last;

  // slot model state
  logic [KEY_W-1:0]         slot_keys [SLOTS];
  int                       slots_filled;
  logic signed [TEMP_W-1:0] round_temp [SLOTS];
  logic                     round_reported [SLOTS];
  logic [CNT_W-1:0]         streak [SLOTS];
  logic                     sensor_seen;
  logic [CNT_W-1:0]         qualify_rounds;

  // traffic bookkeeping
  sensor_beat_t      beats_to_send [$];
  slot_report_t      slot_reports_due [$];
  sensor_beat_t      next_beat;
  logic [ADDR_W-1:0] sensor_pool [SLOTS];
  int                beats_queued   = 0;
  int                beats_accepted = 0;
  logic              in_taken       = 1'b0;
  int                send_idle_pct  = 13;
  int                recv_idle_pct  = 45;
  int                stall_request  = 0;
  int                hold_left      = 0;
  int                mismatches     = 0;
  int                cycle_count    = 0;

  sensor_slot_map_and_qualifier_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .sensor_address   (sensor_address),
    .temperature      (temperature),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot_index       (slot_index),
    .slot_temperature (slot_temperature),
    .has_value        (has_value),
    .awaiting         (awaiting),
    .any_sensor_seen  (any_sensor_seen),
    .last             (last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sensor_slot_map_and_qualifier_unit test failed");
      $finish;
    end
  end

  // key folds the two address halves, bit 0 forced high
  function automatic logic [KEY_W-1:0] sensor_key(input logic [ADDR_W-1:0] addr);
    return (addr[31:0] ^ addr[63:32]) | 32'd1;
  endfunction

  function automatic logic signed [TEMP_W-1:0] random_temp();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // look up or append the slot, then latch the round value
  task automatic absorb_reading(input logic [ADDR_W-1:0] addr,
                                input logic signed [TEMP_W-1:0] temp);
    logic [KEY_W-1:0] key;
    int slot;
    key = sensor_key(addr);
    slot = -1;
    sensor_seen = 1'b1;
    for (int i = 0; i < slots_filled; i++) begin
      if (slot < 0 && slot_keys[i] == key) slot = i;
    end
    if (slot < 0 && slots_filled < SLOTS) begin
      slot_keys[slots_filled] = key;
      slot = slots_filled;
      slots_filled++;
    end
    if (slot >= 0) begin
      round_temp[slot] = temp;
      round_reported[slot] = 1'b1;
    end
  endtask

  // one report per slot, streaks advance or clear, round values drop
  task automatic close_round();
    slot_report_t r;
    for (int i = 0; i < SLOTS; i++) begin
      r.idx = OUT_IDX_W'(i);
      r.shown = 1'b0;
      r.waiting = 1'b0;
      if (round_reported[i]) begin
        if (streak[i] < COUNT_LIMIT) streak[i]++;
        if (streak[i] >= qualify_rounds) r.shown = 1'b1;
        else r.waiting = 1'b1;
      end else begin
        streak[i] = '0;
      end
      r.temp = r.shown ? round_temp[i] : '0;
      r.seen = sensor_seen;
      r.final_slot = (i == SLOTS - 1);
      round_reported[i] = 1'b0;
      round_temp[i] = '0;
      slot_reports_due.push_back(r);
    end
  endtask

  task automatic check_report();
    slot_report_t want;
    if (slot_reports_due.size() == 0) begin
      report_mismatch($sformatf("result for slot %0d with none expected", slot_index));
      return;
    end
    want = slot_reports_due.pop_front();
    if (slot_index !== want.idx)
      report_mismatch($sformatf("slot_index got %0d want %0d", slot_index, want.idx));
    if (slot_temperature !== want.temp)
      report_mismatch($sformatf("slot %0d slot_temperature got %0d want %0d",
                                want.idx, slot_temperature, want.temp));
    if (has_value !== want.shown)
      report_mismatch($sformatf("slot %0d has_value got %b want %b",
                                want.idx, has_value, want.shown));
    if (awaiting !== want.waiting)
      report_mismatch($sformatf("slot %0d awaiting got %b want %b",
                                want.idx, awaiting, want.waiting));
    if (any_sensor_seen !== want.seen)
      report_mismatch($sformatf("slot %0d any_sensor_seen got %b want %b",
                                want.idx, any_sensor_seen, want.seen));
    if (last !== want.final_slot)
      report_mismatch($sformatf("slot %0d last got %b want %b",
                                want.idx, last, want.final_slot));
  endtask

  // monitor: results checked first, then the accepted input beat is modeled
  always @(posedge clk) begin
    in_taken = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) check_report();
      if (in_valid && in_ready) begin
        beats_accepted++;
        if (opcode == OP_READING) absorb_reading(sensor_address, temperature);
        else close_round();
      end
    end
  end

  // driver: a new beat only once the previous one is gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_valid <= 1'b1;
        opcode <= next_beat.op;
        sensor_address <= next_beat.addr;
        temperature <= next_beat.temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus an occasional long hold
  always @(negedge clk) begin
    if (stall_request > 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic settle();
    @(posedge clk);
    #1;
  endtask

  task automatic queue_beat(input opcode_t op, input logic [ADDR_W-1:0] addr,
                            input logic signed [TEMP_W-1:0] temp);
    sensor_beat_t b;
    b.op = op;
    b.addr = addr;
    b.temp = temp;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_drained();
    while (beats_accepted != beats_queued || slot_reports_due.size() != 0) settle();
  endtask

  // register write only once the block has gone quiet
  task automatic write_qualify(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    qualify_rounds = value;
    settle();
  endtask

  // readings from known sensors, aliases and strangers, closed by end of round
  task automatic random_round();
    int n;
    int pick;
    logic [ADDR_W-1:0] a;
    logic [31:0] r;
    n = $urandom_range(9);
    repeat (n) begin
      pick = $urandom_range(99);
      a = sensor_pool[$urandom_range(SLOTS - 1)];
      r = $urandom;
      if (pick < 25) a = a ^ {r, r};
      else if (pick < 35) a = a ^ 64'd1;
      else if (pick >= 90) a = {$urandom, $urandom};
      queue_beat(OP_READING, a, random_temp());
    end
    queue_beat(OP_END_ROUND, {$urandom, $urandom}, random_temp());
  endtask

  task automatic random_phase(input logic [CNT_W-1:0] qual, input int send_pct,
                              input int recv_pct, input int n_items);
    int start;
    write_qualify(qual);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = beats_queued;
    while (beats_queued - start < n_items) begin
      random_round();
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  // stimulus
  initial begin
    logic clash;
    for (int i = 0; i < SLOTS; i++) begin
      slot_keys[i] = '0;
      round_temp[i] = '0;
      round_reported[i] = 1'b0;
      streak[i] = '0;
    end
    slots_filled = 0;
    sensor_seen = 1'b0;
    qualify_rounds = QUALIFY_RESET;

    // sensor population, all keys distinct
    sensor_pool[0] = 64'h00000000_00000000;
    sensor_pool[1] = 64'hFFFFFFFF_00000000;
    sensor_pool[2] = 64'h00000000_80000000;
    for (int i = 3; i < SLOTS; i++) begin
      do begin
        sensor_pool[i] = {$urandom, $urandom};
        clash = (sensor_key(sensor_pool[i]) == sensor_key(STRAY_ADDR));
        for (int j = 0; j < i; j++) begin
          if (sensor_key(sensor_pool[j]) == sensor_key(sensor_pool[i])) clash = 1'b1;
        end
      end while (clash);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // directed: empty round before any sensor
    queue_beat(OP_END_ROUND, '0, '0);
    // extremes, same key from all-zero and all-one address, overwrite
    queue_beat(OP_READING, sensor_pool[0], 16'sh7FFF);
    queue_beat(OP_READING, 64'hFFFFFFFF_FFFFFFFF, 16'sh8000);
    queue_beat(OP_READING, sensor_pool[1], 16'sh0000);
    queue_beat(OP_READING, sensor_pool[2], 16'shFFFF);
    queue_beat(OP_END_ROUND, 64'hFFFFFFFF_FFFFFFFF, 16'sh8000);
    // second round, third sensor missing so its streak clears
    queue_beat(OP_READING, 64'h00000001_00000000, 16'sh0190);
    queue_beat(OP_READING, sensor_pool[1], 16'sd12345);
    queue_beat(OP_END_ROUND, '0, '0);
    // third round reaches the reset threshold for the first two slots
    queue_beat(OP_READING, sensor_pool[0], 16'sh7FFF);
    queue_beat(OP_READING, sensor_pool[1], 16'sh8000);
    queue_beat(OP_READING, sensor_pool[2], 16'sd1);
    queue_beat(OP_END_ROUND, '0, '0);
    // fill the table, then a stranger is dropped
    for (int i = 3; i < SLOTS; i++) queue_beat(OP_READING, sensor_pool[i], random_temp());
    queue_beat(OP_READING, STRAY_ADDR, 16'sh1234);
    queue_beat(OP_END_ROUND, '0, '0);
    queue_beat(OP_END_ROUND, '0, '0);

    // sender idles more rarely than the receiver; one long receiver hold
    random_phase(10'd2, 13, 45, 36);
    stall_request = 300;
    repeat (3) random_round();
    wait_drained();
    repeat (2) random_round();

    // roles swapped: threshold zero, then beyond the count limit
    random_phase(10'd0, 45, 13, 36);
    random_phase(10'd1023, 45, 13, 36);

    // no idling: one slot reports every round against the count-limit threshold
    write_qualify(COUNT_LIMIT);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) begin
      queue_beat(OP_READING, sensor_pool[4], random_temp());
      if ($urandom_range(1) == 1)
        queue_beat(OP_READING, sensor_pool[$urandom_range(SLOTS - 1)], random_temp());
      queue_beat(OP_END_ROUND, {$urandom, $urandom}, random_temp());
    end
    random_phase(10'd1, 0, 0, 36);
    random_phase(10'd5, 0, 0, 36);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sensor_slot_map_and_qualifier_unit test passed");
    end else begin
      $display("sensor_slot_map_and_qualifier_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ssmq_pkg.sv
design/ssmq_ram.sv
design/sensor_slot_map_and_qualifier_unit.sv
tb/tb_top.sv
